@@ rtl/rltt_pkg.sv @@
`timescale 1ns / 1ps

package rltt_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_CALC,
        ST_MUL,
        ST_DONE
    } rltt_state_t;

    // Operation codes carried on the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // Result status codes carried on the output tuser.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOR     = 2'd1;
    localparam logic [1:0] STAT_WRITTEN = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TRACE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRACE_LEN   = 2'd1;
    localparam logic [1:0] CFG_ACTIVE      = 2'd2;

    // Stream widths.
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 88;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_wr;
        logic take_xl;
        logic rd_en;
        logic calc;
        logic mul;
        logic load_out;
    } rltt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_end;
        logic out_free;
    } rltt_stat_t;

endpackage

@@ rtl/rltt_ctrl.sv @@
`timescale 1ns / 1ps

module rltt_ctrl
    import rltt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic       s_axis_tuser,
    input  rltt_stat_t stat,
    output rltt_cmd_t  cmd
);

    rltt_state_t state_reg;
    rltt_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_WRITE)
                    begin
                        cmd.take_wr = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.take_xl = 1'b1;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A translate transaction always starts the table walk.
    a_xlate_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_XLATE)
        |=> (state_reg == ST_WALK))
        else $error("translate did not start the walk");

    // A finished result waits while the output register is occupied.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !stat.out_free) |=> (state_reg == ST_DONE))
        else $error("result left while output was busy");

    // The product is always followed by the result hand-off.
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_DONE))
        else $error("multiply not followed by result");

endmodule

@@ rtl/rltt_datapath.sv @@
`timescale 1ns / 1ps

module rltt_datapath
    import rltt_pkg::*;
#(
    parameter int MAX_RANGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  rltt_cmd_t              cmd,
    output rltt_stat_t             stat
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [8:0] MAX9 = 9'(MAX_RANGES);

    // Input item fields.
    logic [3:0]  entry_slot;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic        range_open;
    logic [31:0] logical_index;

    assign entry_slot    = s_axis_tdata[3:0];
    assign range_first   = s_axis_tdata[35:4];
    assign range_last    = s_axis_tdata[67:36];
    assign range_open    = s_axis_tdata[68];
    assign logical_index = s_axis_tdata[100:69];

    // Configuration registers.
    logic [31:0] count_reg;
    logic [23:0] tlen_reg;
    logic [4:0]  active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            tlen_reg   <= '0;
            active_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TRACE_COUNT: count_reg  <= cfg_data;
                CFG_TRACE_LEN:   tlen_reg   <= cfg_data[23:0];
                CFG_ACTIVE:      active_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // Entries in use, clamped to the table depth.
    logic [8:0]    act9;
    logic [8:0]    used9;
    logic [CW-1:0] used_cnt;

    assign act9     = {4'b0, active_reg};
    assign used9    = (act9 > MAX9) ? MAX9 : act9;
    assign used_cnt = used9[CW-1:0];

    // Range table.
    logic [31:0] start_mem [MAX_RANGES];
    logic [31:0] stop_mem  [MAX_RANGES];
    logic        open_mem  [MAX_RANGES];
    logic [8:0]  wr_slot9;
    logic        wr_ok;

    assign wr_slot9 = {5'b0, entry_slot};
    assign wr_ok    = (wr_slot9 < MAX9);

    always_ff @(posedge clk)
    begin
        if (cmd.take_wr && wr_ok)
        begin
            start_mem[wr_slot9[AW-1:0]] <= range_first;
            stop_mem[wr_slot9[AW-1:0]]  <= range_last;
            open_mem[wr_slot9[AW-1:0]]  <= range_open;
        end
    end

    // Walk counter and registered table read.
    logic [CW-1:0] rd_cnt_reg;
    logic          rd_vld_reg;
    logic [31:0]   rd_first_reg;
    logic [31:0]   rd_last_reg;
    logic          rd_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.take_xl)
            begin
                rd_cnt_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_first_reg <= start_mem[rd_cnt_reg[AW-1:0]];
            rd_last_reg  <= stop_mem[rd_cnt_reg[AW-1:0]];
            rd_open_reg  <= open_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    assign stat.walk_end = (rd_cnt_reg == used_cnt);

    // Length of the entry just read.
    logic [32:0] len_next;
    logic [32:0] len_reg;
    logic [31:0] len_first_reg;
    logic        len_vld_reg;

    always_comb
    begin
        if (rd_open_reg)
        begin
            len_next = (rd_first_reg < count_reg) ?
                       {1'b0, count_reg - rd_first_reg} : 33'd0;
        end
        else
        begin
            len_next = (rd_last_reg >= rd_first_reg) ?
                       ({1'b0, rd_last_reg - rd_first_reg} + 33'd1) : 33'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= 1'b0;
        end
        else
        begin
            len_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            len_reg       <= len_next;
            len_first_reg <= rd_first_reg;
        end
    end

    // Search: the running total never passes the index while searching,
    // so the distance to it fits in 32 bits.
    logic [31:0] idx_reg;
    logic [31:0] before_reg;
    logic        found_reg;
    logic        wr_mode_reg;
    logic [31:0] diff;
    logic        hit;
    logic [31:0] hit_first_reg;
    logic [31:0] hit_diff_reg;

    assign diff = idx_reg - before_reg;
    assign hit  = ({1'b0, diff} < len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            wr_mode_reg <= 1'b0;
        end
        else if (cmd.take_wr)
        begin
            wr_mode_reg <= 1'b1;
        end
        else if (cmd.take_xl)
        begin
            wr_mode_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (len_vld_reg && !found_reg && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_xl)
        begin
            idx_reg    <= logical_index;
            before_reg <= '0;
        end
        else if (len_vld_reg && !found_reg)
        begin
            if (hit)
            begin
                hit_first_reg <= len_first_reg;
                hit_diff_reg  <= diff;
            end
            else
            begin
                before_reg <= before_reg + len_reg[31:0];
            end
        end
    end

    // Physical trace and byte offset.
    logic [31:0] phys_reg;
    logic [55:0] offs_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            phys_reg <= hit_first_reg + hit_diff_reg;
        end
        if (cmd.mul)
        begin
            offs_reg <= 56'(phys_reg) * 56'(tlen_reg);
        end
    end

    // Output register.
    logic        out_vld_reg;
    logic [1:0]  out_stat_reg;
    logic [31:0] out_phys_reg;
    logic [55:0] out_offs_reg;

    assign stat.out_free = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (wr_mode_reg)
            begin
                out_stat_reg <= STAT_WRITTEN;
                out_phys_reg <= '0;
                out_offs_reg <= '0;
            end
            else if (found_reg)
            begin
                out_stat_reg <= STAT_OK;
                out_phys_reg <= phys_reg;
                out_offs_reg <= offs_reg;
            end
            else
            begin
                out_stat_reg <= STAT_OOR;
                out_phys_reg <= '0;
                out_offs_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign m_axis_tdata  = {out_offs_reg, out_phys_reg};

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_vld_reg || m_axis_tready))
        else $error("result loaded over a waiting result");

    // A hit is only forgotten when a new translation starts.
    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(found_reg) |-> $past(cmd.take_xl))
        else $error("hit lost during translation");

    // The walk never reads past the entries in use.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_cnt_reg < used_cnt))
        else $error("walk read beyond active entries");

endmodule

@@ rtl/range_list_trace_translate.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Contents
// s_axis    in         tvalid tready tdata tuser      range write or translate request
// m_axis    out        tvalid tready tdata tuser      status, trace number, byte offset
// cfg       in         valid ready index data         trace count, trace length, entries
//
// A range write goes straight to the result stage. A translation walks
// N entries, N being the active entry count clamped to MAX_RANGES, reading
// one table entry per cycle through one port.
// Reset clears all control state and the configuration registers; table
// entries are undefined until written. A result waits in the output
// register while m_axis_tready is low, and the next input transaction is
// taken meanwhile.
module range_list_trace_translate
    import rltt_pkg::*;
#(
    parameter int MAX_RANGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_slot[3:0], range_first[35:4], range_last[67:36],
    // range_open[68], logical_index[100:69], zero padding[103:101]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // physical_trace[31:0], byte_offset[87:32]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]             m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    rltt_cmd_t  cmd;
    rltt_stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    rltt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Range table, walk and result datapath.
    rltt_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

@@ verif/tb_range_list_trace_translate.sv @@
`timescale 1ns / 1ps

module tb_range_list_trace_translate;
    import rltt_pkg::*;

    localparam int MAX_ENTRIES   = 16;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 30;

    // One request as offered on the input stream.
    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [31:0] lo_trace;
        logic [31:0] hi_trace;
        logic        to_end;
        logic [31:0] index;
    } request_t;

    // One translation answer as it should leave the block.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] trace;
        logic [55:0] offset;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_WRITE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = CFG_TRACE_COUNT;
    logic [31:0]            cfg_data = '0;

    range_list_trace_translate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Requests waiting to be driven and answers waiting to come out.
    request_t request_q[$];
    answer_t  answer_q[$];

    // Table and registers as the block should hold them, updated on acceptance.
    logic [31:0] tbl_lo [MAX_ENTRIES];
    logic [31:0] tbl_hi [MAX_ENTRIES];
    logic        tbl_to_end [MAX_ENTRIES];
    logic [31:0] reg_count = '0;
    logic [23:0] reg_len = '0;
    logic [4:0]  reg_active = '0;

    // Table and registers as the stimulus generator expects them to be.
    logic [31:0] plan_lo [MAX_ENTRIES];
    logic [31:0] plan_hi [MAX_ENTRIES];
    logic        plan_to_end [MAX_ENTRIES];
    logic [31:0] plan_count = '0;
    logic [4:0]  plan_active = '0;

    int       error_count = 0;
    int       results_seen = 0;
    logic     in_fire = 1'b0;
    request_t drive_req;
    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_mode = 0;
    int       rx_mode_left = 0;
    int       hold_left = 0;
    logic     long_hold_done = 1'b0;

    // Number of traces covered by one table entry.
    function automatic logic [32:0] span_of(logic [31:0] lo, logic [31:0] hi, logic to_end,
                                            logic [31:0] count);
        if (to_end)
            return (lo < count) ? {1'b0, count} - {1'b0, lo} : 33'd0;
        return (hi >= lo) ? {1'b0, hi} - {1'b0, lo} + 33'd1 : 33'd0;
    endfunction

    // Works out the answer to one accepted request and applies any table write.
    function automatic answer_t translate_item(logic op, logic [IN_TDATA_W-1:0] d);
        answer_t     ans;
        logic [3:0]  slot;
        logic [31:0] idx;
        logic [63:0] total;
        logic [63:0] base;
        logic [63:0] len;
        logic        found;
        int          used;
        ans = '0;
        if (op == OP_WRITE)
        begin
            slot = d[3:0];
            tbl_lo[slot] = d[35:4];
            tbl_hi[slot] = d[67:36];
            tbl_to_end[slot] = d[68];
            ans.status = STAT_WRITTEN;
        end
        else
        begin
            idx = d[100:69];
            used = (reg_active > MAX_ENTRIES) ? MAX_ENTRIES : int'(reg_active);
            total = '0;
            for (int k = 0; k < used; k++)
                total += 64'(span_of(tbl_lo[k], tbl_hi[k], tbl_to_end[k], reg_count));
            if ({32'd0, idx} >= total)
            begin
                ans.status = STAT_OOR;
            end
            else
            begin
                ans.status = STAT_OK;
                base = '0;
                found = 1'b0;
                for (int k = 0; k < used; k++)
                begin
                    len = 64'(span_of(tbl_lo[k], tbl_hi[k], tbl_to_end[k], reg_count));
                    if (!found && {32'd0, idx} < base + len)
                    begin
                        ans.trace = tbl_lo[k] + 32'({32'd0, idx} - base);
                        found = 1'b1;
                    end
                    base += len;
                end
                ans.offset = {24'd0, ans.trace} * {32'd0, reg_len};
            end
        end
        return ans;
    endfunction

    // Filtered length of the first upto entries, as the generator sees the table.
    function automatic logic [63:0] plan_prefix(int upto);
        logic [63:0] sum;
        int          used;
        sum = '0;
        used = (plan_active > MAX_ENTRIES) ? MAX_ENTRIES : int'(plan_active);
        for (int k = 0; k < upto && k < used; k++)
            sum += 64'(span_of(plan_lo[k], plan_hi[k], plan_to_end[k], plan_count));
        return sum;
    endfunction

    function automatic void queue_write(logic [3:0] slot, logic [31:0] lo, logic [31:0] hi,
                                        logic to_end);
        request_t r;
        r.op = OP_WRITE;
        r.slot = slot;
        r.lo_trace = lo;
        r.hi_trace = hi;
        r.to_end = to_end;
        r.index = $urandom;
        plan_lo[slot] = lo;
        plan_hi[slot] = hi;
        plan_to_end[slot] = to_end;
        request_q.push_back(r);
    endfunction

    function automatic void queue_translate(logic [31:0] idx);
        request_t r;
        r.op = OP_XLATE;
        r.slot = 4'($urandom);
        r.lo_trace = $urandom;
        r.hi_trace = $urandom;
        r.to_end = 1'($urandom);
        r.index = idx;
        request_q.push_back(r);
    endfunction

    // Waits until every request has gone in and every answer has come out.
    task automatic wait_idle();
        while (request_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Loads all three registers; only called while the block is idle.
    task automatic set_regs(logic [31:0] count, logic [31:0] len_word, logic [31:0] act_word);
        write_reg(CFG_TRACE_COUNT, count);
        write_reg(CFG_TRACE_LEN, len_word);
        write_reg(CFG_ACTIVE, act_word);
        @(negedge clk);
        cfg_valid <= 1'b0;
        plan_count = count;
        plan_active = act_word[4:0];
    endtask

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Input driver: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_axis_tvalid && !in_fire)
        begin
            // Current transaction not yet taken, so it stays on the bus.
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end
        else if (request_q.size() > 0)
        begin
            drive_req = request_q.pop_front();
            s_axis_tdata <= {3'b000, drive_req.index, drive_req.to_end, drive_req.hi_trace,
                             drive_req.lo_trace, drive_req.slot};
            s_axis_tuser <= drive_req.op;
            s_axis_tvalid <= 1'b1;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = 0;
                    end
                    4, 5, 6, 7:
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = $urandom_range(1, 6);
                    end
                    8:
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = $urandom_range(15, 60);
                    end
                    default:
                    begin
                        burst_left = 150;
                        gap_left = 0;
                    end
                endcase
            end
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Output backpressure: changing stall patterns plus one long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 200)
        begin
            long_hold_done = 1'b1;
            hold_left = 250;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 4);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                2:       m_axis_tready <= 1'($urandom_range(0, 1));
                3:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                4:
                begin
                    hold_left = $urandom_range(10, 60);
                    rx_mode_left = 0;
                    m_axis_tready <= 1'b0;
                end
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Monitor: checks answers, predicts on accepted requests, tracks register writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (answer_q.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d trace %0d",
                           m_axis_tuser, m_axis_tdata[31:0]);
                    error_count++;
                end
                else
                begin
                    answer_t exp_ans;
                    exp_ans = answer_q.pop_front();
                    if (m_axis_tuser !== exp_ans.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_ans.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[31:0] !== exp_ans.trace)
                    begin
                        $error("physical_trace mismatch: expected %0d, actual %0d",
                               exp_ans.trace, m_axis_tdata[31:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[87:32] !== exp_ans.offset)
                    begin
                        $error("byte_offset mismatch: expected %0d, actual %0d",
                               exp_ans.offset, m_axis_tdata[87:32]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                answer_q.push_back(translate_item(s_axis_tuser, s_axis_tdata));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRACE_COUNT: reg_count = cfg_data;
                    CFG_TRACE_LEN:   reg_len = cfg_data[23:0];
                    CFG_ACTIVE:      reg_active = cfg_data[4:0];
                    default:         ;
                endcase
            end
        end
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Stimulus sequence and end of test.
    initial
    begin
        logic [31:0] lo;
        logic [31:0] cnt;
        logic [31:0] idx;
        logic [31:0] len_word;
        logic [31:0] act_word;
        logic [63:0] tot;
        logic [63:0] bound;
        logic [63:0] r64;
        int          pick;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every kind of entry, then indices on the entry boundaries.
        set_regs(32'd100, 32'h00FF_FFFF, 32'd16);
        queue_write(4'd0, 32'd10, 32'd19, 1'b0);
        queue_write(4'd1, 32'd0, 32'd0, 1'b0);
        queue_write(4'd2, 32'd50, 32'd40, 1'b0);
        queue_write(4'd3, 32'd95, $urandom, 1'b1);
        queue_write(4'd4, 32'd100, $urandom, 1'b1);
        queue_write(4'd5, 32'hFFFF_FFFF, $urandom, 1'b1);
        queue_write(4'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_write(4'd7, 32'd1000, 32'd1003, 1'b0);
        for (int s = 8; s < 15; s++)
        begin
            lo = $urandom;
            queue_write(4'(s), lo, lo + 32'($urandom_range(0, 5)), 1'b0);
        end
        queue_write(4'd15, 32'd0, 32'hFFFF_FFFF, 1'b0);
        queue_translate(32'd0);
        queue_translate(32'(plan_prefix(3)));
        queue_translate(32'(plan_prefix(6)));
        queue_translate(32'(plan_prefix(15) - 64'd1));
        queue_translate(32'(plan_prefix(15)));
        queue_translate(32'hFFFF_FFFF);
        wait_idle();

        // Entry count above the table size, no stored traces, zero trace length.
        set_regs(32'd0, 32'd0, 32'd31);
        queue_translate(32'd0);
        queue_translate(32'hFFFF_FFFF);
        wait_idle();

        // No active entries: every index falls outside the sequence.
        set_regs(32'hFFFF_FFFF, 32'd1, 32'd0);
        queue_translate(32'd0);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 5)
                0:       cnt = 32'd0;
                1:       cnt = $urandom_range(1, 64);
                2:       cnt = 32'hFFFF_FFFF;
                3:       cnt = $urandom;
                default: cnt = $urandom_range(100, 5000);
            endcase
            case (p % 4)
                0:       len_word = 32'h00FF_FFFF;
                1:       len_word = 32'd0;
                2:       len_word = 32'd1;
                default: len_word = {8'($urandom), 24'($urandom)};
            endcase
            case (p)
                0, 4, 7: act_word = 32'd16;
                1:       act_word = 32'd1;
                2:       act_word = 32'd31;
                6:       act_word = 32'($urandom_range(17, 30));
                9:       act_word = 32'd3;
                default: act_word = {27'($urandom), 5'($urandom_range(2, 15))};
            endcase
            set_regs(cnt, len_word, act_word);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                        begin
                            lo = $urandom;
                            queue_write(4'($urandom), lo, lo + 32'($urandom_range(0, 40)),
                                        1'b0);
                        end
                        4:
                        begin
                            lo = $urandom;
                            queue_write(4'($urandom), lo, lo, 1'b0);
                        end
                        5:
                        begin
                            lo = $urandom | 32'h0000_1000;
                            queue_write(4'($urandom), lo, lo - 32'($urandom_range(1, 100)),
                                        1'b0);
                        end
                        6, 7:
                        begin
                            // Open entries mostly end a short way past their first trace.
                            if (plan_count > 32'd60)
                                lo = plan_count - 32'($urandom_range(0, 60));
                            else
                                lo = $urandom_range(0, plan_count + 32'd2);
                            queue_write(4'($urandom), lo, $urandom, 1'b1);
                        end
                        8:
                        begin
                            queue_write(4'($urandom), 32'($urandom_range(0, 1000)), $urandom,
                                        1'b0);
                        end
                        default:
                        begin
                            queue_write(4'($urandom), $urandom, $urandom, 1'($urandom));
                        end
                    endcase
                end
                else
                begin
                    tot = plan_prefix(MAX_ENTRIES);
                    pick = $urandom_range(0, 19);
                    if (pick < 8)
                    begin
                        // Land just before, on or after the start of some entry.
                        bound = plan_prefix($urandom_range(0, MAX_ENTRIES));
                        idx = bound[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                    else if (pick < 15 && tot != 64'd0)
                    begin
                        r64 = {$urandom, $urandom};
                        idx = 32'(r64 % tot);
                    end
                    else if (pick == 17)
                    begin
                        idx = 32'(tot - 64'd1);
                    end
                    else if (pick == 18)
                    begin
                        idx = 32'(tot);
                    end
                    else if (pick == 19)
                    begin
                        idx = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                    end
                    else
                    begin
                        idx = $urandom;
                    end
                    queue_translate(idx);
                end
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rltt_pkg.sv
rtl/rltt_ctrl.sv
rtl/rltt_datapath.sv
rtl/range_list_trace_translate.sv
verif/tb_range_list_trace_translate.sv
